// ----- sv/wrr_pkg.sv -----
package wrr_pkg;

  localparam int unsigned MAX_REF_DEF = 1024;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_DEGEN = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ORDER = 3'd4;

  localparam logic        REG_WINDOW_SIZE = 1'b0;
  localparam logic [10:0] WINDOW_RESET    = 11'd3;
  localparam logic [10:0] WINDOW_MIN      = 11'd2;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_ctl_t;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_RND} arith_state_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SINGLE_RD, S_SINGLE_LD, S_SRCH_RD, S_SRCH_CMP, S_PLACE,
    S_T0_RD, S_T0_LD, S_ACC_LD, S_ACC_M1, S_ACC_M2, S_ACC_M3,
    S_CALC_GO, S_CALC_WAIT, S_DIV_GO, S_DIV_WAIT, S_FIN, S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    C_NSXX, C_SXSX, C_NSXY, C_SXSY, C_DN, C_SYD, C_NMM, C_NDEN
  } calc_step_e;

endpackage

// ----- sv/windowed_regression_reference.sv -----
// channel  | direction | handshake                  | payload
// in       | input     | in_valid_i / in_stall_o    | cmd_i, sample_time_i, sample_value_i
// out      | output    | out_valid_o / out_stall_i  | status_o, ref_estimate_o, difference_o,
//          |           |                            | window_used_o
// cfg      | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// Clear, append and unused commands go straight to the result. A query runs a
// binary search over the table RAM when it holds more entries than the window,
// loads and multiplies each window word in the 33x33 multiplier, then up to eight
// shift-add products and a 3*CW+100 step restoring division in the shared wide adder.
// Reset is asynchronous and empties the table; window_size returns to 3.
// in_stall_o is high while a word is in work; a stalled result holds the
// finished word in the block until out_stall_i drops.
module windowed_regression_reference import wrr_pkg::*; #(
  parameter int unsigned MAX_REF = MAX_REF_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        sample_time_i,
  input  logic signed [31:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] ref_estimate_o,
  output logic signed [31:0] difference_o,
  output logic [10:0]        window_used_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CW = $clog2(MAX_REF+1);
  localparam int unsigned AW = $clog2(MAX_REF);
  localparam int unsigned W  = 3*CW + 100;
  localparam int unsigned EW = ((CW > 11) ? CW : 11) + 1;

  ctrl_state_e state_q, state_d;
  calc_step_e  step_q;

  logic [10:0]        window_size_q;
  logic [CW-1:0]      count_q, lo_q, hi_q, mid_q, start_q, cnt_q, i_q;
  logic [31:0]        last_time_q, t_q, t0_q, x_q;
  logic signed [31:0] val_q, y_q, est_q;
  logic signed [32:0] d_q;
  logic signed [65:0] prod_q;
  logic signed [W-1:0] sx_q, sy_q, sxx_q, sxy_q, tmp_q, dd_q, nn_q, mm_q, num_q, den_q;
  logic               degen_q;

  logic [2:0]         res_status_q;
  logic signed [31:0] res_est_q, res_diff_q;
  logic [10:0]        res_used_q;
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic signed [31:0] out_est_q, out_diff_q;
  logic [10:0]        out_used_q;

  logic               in_acc, out_free, wide, ram_we, dd_zero;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid, base;
  logic [AW-1:0]      raddr;
  logic [63:0]        rdata;
  logic [31:0]        rd_time, x;
  logic signed [31:0] rd_value, quot;
  logic [10:0]        wsz;
  logic [EW-1:0]      n_ext, w_ext, lim;
  logic signed [EW-1:0] p, start_sel;
  logic signed [32:0] mop_b;
  logic signed [65:0] mprod;
  logic signed [33:0] dv;
  logic signed [31:0] dsat;
  logic signed [W-1:0] n_w, ca, cb, ures, dd_diff;
  arith_ctl_t         actl;
  logic               adone;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CW:1];
  assign base     = start_q + i_q;
  assign rd_time  = rdata[63:32];
  assign rd_value = rdata[31:0];
  assign x        = rd_time - t0_q;
  assign wsz      = (window_size_q < WINDOW_MIN) ? WINDOW_MIN : window_size_q;
  assign n_ext    = EW'(count_q);
  assign w_ext    = EW'(wsz);
  assign wide     = n_ext > w_ext;
  assign lim      = n_ext - w_ext;
  assign p        = $signed(EW'(lo_q)) - $signed(EW'(wsz >> 1));
  assign start_sel = (p < 0) ? '0 : ((p > $signed(lim)) ? $signed(lim) : p);
  assign ram_we   = in_acc && (cmd_i == CMD_APPEND) && (count_q < CW'(MAX_REF)) &&
                    !((count_q != '0) && (sample_time_i < last_time_q));
  assign n_w      = W'(cnt_q);
  assign dd_diff  = tmp_q - ures;
  assign dd_zero  = (dd_diff == '0);
  assign dv       = 34'(val_q) - 34'(est_q);
  assign dsat     = (dv > 34'sh07fffffff) ? 32'sh7fffffff :
                    (dv < -34'sh080000000) ? 32'sh80000000 : dv[31:0];
  assign mprod    = $signed({1'b0, x_q}) * mop_b;

  wrr_ram #(.WIDTH(64), .DEPTH(MAX_REF)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({sample_time_i, sample_value_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wrr_arith #(.W(W)) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (actl),
    .a_i    ((state_q == S_DIV_GO) ? num_q : ca),
    .b_i    ((state_q == S_DIV_GO) ? den_q : cb),
    .done_o (adone),
    .prod_o (ures),
    .quot_o (quot)
  );

  always_comb begin
    case (step_q)
      C_NSXX:  begin ca = sxx_q;     cb = n_w;  end
      C_SXSX:  begin ca = sx_q;      cb = sx_q; end
      C_NSXY:  begin ca = sxy_q;     cb = n_w;  end
      C_SXSY:  begin ca = sx_q;      cb = sy_q; end
      C_DN:    begin ca = W'(d_q);   cb = n_w;  end
      C_SYD:   begin ca = dd_q;      cb = sy_q; end
      C_NMM:   begin ca = nn_q;      cb = mm_q; end
      default: begin ca = dd_q;      cb = n_w;  end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i != CMD_QUERY || count_q == '0) begin
            state_d = S_DONE;
          end else if (count_q == CW'(1)) begin
            state_d = S_SINGLE_RD;
          end else if (wide) begin
            state_d = S_SRCH_RD;
          end else begin
            state_d = S_T0_RD;
          end
        end
      end
      S_SINGLE_RD: state_d = S_SINGLE_LD;
      S_SINGLE_LD: state_d = S_FIN;
      S_SRCH_RD:   state_d = (lo_q < hi_q) ? S_SRCH_CMP : S_PLACE;
      S_SRCH_CMP:  state_d = S_SRCH_RD;
      S_PLACE:     state_d = S_T0_RD;
      S_T0_RD:     state_d = S_T0_LD;
      S_T0_LD:     state_d = S_ACC_LD;
      S_ACC_LD:    state_d = S_ACC_M1;
      S_ACC_M1:    state_d = S_ACC_M2;
      S_ACC_M2:    state_d = S_ACC_M3;
      S_ACC_M3:    state_d = (i_q == cnt_q) ? S_CALC_GO : S_ACC_LD;
      S_CALC_GO:   state_d = S_CALC_WAIT;
      S_CALC_WAIT: begin
        if (adone) begin
          if ((step_q == C_SXSX && dd_zero) || step_q == C_NDEN) begin
            state_d = S_DIV_GO;
          end else begin
            state_d = S_CALC_GO;
          end
        end
      end
      S_DIV_GO:    state_d = S_DIV_WAIT;
      S_DIV_WAIT:  state_d = adone ? S_FIN : S_DIV_WAIT;
      S_FIN:       state_d = S_DONE;
      S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    raddr      = (state_q == S_SRCH_RD) ? mid[AW-1:0] : base[AW-1:0];
    mop_b      = (state_q == S_ACC_M1) ? $signed({1'b0, x_q}) : $signed({y_q[31], y_q});
    actl.start = (state_q == S_CALC_GO) || (state_q == S_DIV_GO);
    actl.op    = (state_q == S_DIV_GO) ? OP_DIV : OP_MUL;
    prdata     = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size_q) : '0;
    pready     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      window_size_q <= WINDOW_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
        window_size_q <= pwdata[10:0];
      end
      if (in_acc && cmd_i == CMD_CLEAR) begin
        count_q <= '0;
      end else if (ram_we) begin
        count_q <= count_q + CW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      last_time_q <= sample_time_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_est_q    <= res_est_q;
      out_diff_q   <= res_diff_q;
      out_used_q   <= res_used_q;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          t_q       <= sample_time_i;
          val_q     <= sample_value_i;
          start_q   <= '0;
          cnt_q     <= count_q;
          i_q       <= '0;
          lo_q      <= '0;
          hi_q      <= count_q;
          degen_q   <= 1'b0;
          step_q    <= C_NSXX;
          res_est_q <= '0;
          res_diff_q <= '0;
          res_used_q <= '0;
          res_status_q <= ST_OK;
          case (cmd_i)
            CMD_APPEND: begin
              if (count_q >= CW'(MAX_REF)) begin
                res_status_q <= ST_FULL;
              end else if (!ram_we) begin
                res_status_q <= ST_ORDER;
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                res_status_q <= ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_SINGLE_LD: est_q <= rd_value;
      S_SRCH_RD:   mid_q <= mid;
      S_SRCH_CMP: begin
        if (rd_time < t_q) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      S_PLACE: begin
        start_q <= CW'(start_sel);
        cnt_q   <= CW'(w_ext);
      end
      S_T0_LD: begin
        t0_q  <= rd_time;
        d_q   <= $signed({1'b0, t_q}) - $signed({1'b0, rd_time});
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        sxy_q <= '0;
      end
      S_ACC_LD: begin
        x_q  <= x;
        y_q  <= rd_value;
        sx_q <= sx_q + W'(x);
        sy_q <= sy_q + W'(rd_value);
        i_q  <= i_q + CW'(1);
      end
      S_ACC_M1: prod_q <= mprod;
      S_ACC_M2: begin
        sxx_q  <= sxx_q + W'(prod_q);
        prod_q <= mprod;
      end
      S_ACC_M3: sxy_q <= sxy_q + W'(prod_q);
      S_CALC_WAIT: begin
        if (adone) begin
          case (step_q)
            C_NSXX: begin
              tmp_q  <= ures;
              step_q <= C_SXSX;
            end
            C_SXSX: begin
              dd_q <= dd_diff;
              if (dd_zero) begin
                degen_q <= 1'b1;
                num_q   <= sy_q;
                den_q   <= n_w;
              end
              step_q <= C_NSXY;
            end
            C_NSXY: begin
              tmp_q  <= ures;
              step_q <= C_SXSY;
            end
            C_SXSY: begin
              nn_q   <= dd_diff;
              step_q <= C_DN;
            end
            C_DN: begin
              mm_q   <= ures - sx_q;
              step_q <= C_SYD;
            end
            C_SYD: begin
              num_q  <= ures;
              step_q <= C_NMM;
            end
            C_NMM: begin
              num_q  <= num_q + ures;
              step_q <= C_NDEN;
            end
            default: den_q <= ures;
          endcase
        end
      end
      S_DIV_WAIT: begin
        if (adone) begin
          est_q <= quot;
        end
      end
      S_FIN: begin
        res_status_q <= degen_q ? ST_DEGEN : ST_OK;
        res_est_q    <= est_q;
        res_diff_q   <= dsat;
        res_used_q   <= 11'(cnt_q);
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign ref_estimate_o = out_est_q;
  assign difference_o   = out_diff_q;
  assign window_used_o  = out_used_q;

endmodule

// ----- sv/wrr_ram.sv -----
module wrr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/wrr_arith.sv -----
module wrr_arith import wrr_pkg::*; #(
  parameter int unsigned W = 136
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arith_ctl_t          ctl_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic [W-1:0]        prod_o,
  output logic [31:0]         quot_o
);

  localparam int unsigned CNT_W = $clog2(W+1);

  arith_state_e     state_q, state_d;
  logic [W-1:0]     a_q, b_q, acc_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;

  logic [W-1:0] rs, q_r;
  logic         ge, b_zero;

  assign rs     = {acc_q[W-2:0], a_q[W-1]};
  assign ge     = rs >= b_q;
  assign b_zero = (b_q == '0);
  assign q_r    = a_q + W'({acc_q[W-2:0], 1'b0} >= b_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: begin
        if (ctl_i.start) begin
          state_d = (ctl_i.op == OP_MUL) ? U_MUL : U_DIV;
        end
      end
      U_MUL: begin
        if (b_zero) begin
          state_d = U_IDLE;
        end
      end
      U_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = U_RND;
        end
      end
      U_RND:   state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    done_o = ((state_q == U_MUL) && b_zero) || (state_q == U_RND);
    prod_o = acc_q;
    if (neg_q) begin
      quot_o = (q_r > W'(33'h080000000)) ? 32'h80000000 : 32'(~q_r[31:0] + 32'd1);
    end else begin
      quot_o = (q_r > W'(32'h7fffffff)) ? 32'h7fffffff : q_r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (ctl_i.start) begin
          acc_q <= '0;
          cnt_q <= CNT_W'(W);
          if (ctl_i.op == OP_MUL) begin
            neg_q <= 1'b0;
            a_q   <= b_i[W-1] ? -a_i : a_i;
            b_q   <= b_i[W-1] ? -b_i : b_i;
          end else begin
            neg_q <= a_i[W-1];
            a_q   <= a_i[W-1] ? -a_i : a_i;
            b_q   <= b_i;
          end
        end
      end
      U_MUL: begin
        if (!b_zero) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= {a_q[W-2:0], 1'b0};
          b_q <= {1'b0, b_q[W-1:1]};
        end
      end
      U_DIV: begin
        acc_q <= ge ? rs - b_q : rs;
        a_q   <= {a_q[W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule
